>>> rtl/onrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octahedral normal decoder package
// Shared widths, constants and the sideband type that travels with each
// pixel through the decoder pipeline.
// ----------------------------------------------------------------------------
package onrm_pkg;

  localparam int unsigned FRAC_BITS_DEF = 14;

  localparam int unsigned ENC_W = 8;
  localparam int unsigned MAT_W = 8;
  localparam int unsigned NRM_W = 16;
  localparam int unsigned MAG_W = 8;
  localparam int unsigned SQ_W  = 16;
  localparam int unsigned SUM_W = 18;
  localparam int unsigned LANES = 3;

  localparam logic [MAG_W:0]   ENC_FULL    = 9'd255;
  localparam logic [NRM_W-1:0] NRM_POS_MAX = 16'h7FFF;
  localparam logic [NRM_W-1:0] NRM_NEG_MAX = 16'h8000;

  // Sideband of one pixel: pass-through fields and the sign of each component.
  typedef struct packed {
    logic [MAT_W-1:0] material;
    logic             frame_end;
    logic [LANES-1:0] neg;
  } onrm_meta_t;

endpackage

>>> rtl/octahedral_normal_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octahedral normal decoder
// Decodes one G-buffer pixel from two octahedral bytes into a signed unit
// normal and passes the material ID and frame-end mark alongside it.
// ----------------------------------------------------------------------------
// The decoder takes one pixel request per clock unless stalled and returns
// one result per request in the same order: three front stages unfold and
// square the components, FRAC_BITS + 1 root stages each settle one bit of the
// rounded scaled magnitude with a compare-subtract on a 2*FRAC_BITS + 24 bit
// remainder, and a final stage saturates into the output register. Stall
// only holds up stages that are full, so bubbles are squeezed out and a
// stalled output still lets new requests in until the pipeline is full.
module octahedral_normal_decoder_top #(
  parameter int unsigned FRAC_BITS = onrm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [onrm_pkg::ENC_W-1:0]         enc_x_i,
  input  logic [onrm_pkg::ENC_W-1:0]         enc_y_i,
  input  logic [onrm_pkg::MAT_W-1:0]         material_in_i,
  input  logic                               frame_end_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [onrm_pkg::NRM_W-1:0]  normal_x_o,
  output logic signed [onrm_pkg::NRM_W-1:0]  normal_y_o,
  output logic signed [onrm_pkg::NRM_W-1:0]  normal_z_o,
  output logic [onrm_pkg::MAT_W-1:0]         material_out_o,
  output logic                               frame_end_out_o
);
  import onrm_pkg::*;

  localparam int unsigned W   = 2 * FRAC_BITS + 24;
  localparam int unsigned KW  = FRAC_BITS + 1;
  localparam int unsigned NST = FRAC_BITS + 1;
  localparam int          LIM_HI_I = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
  localparam int          LIM_LO_I = (FRAC_BITS >= 15) ? -32768 : -(1 << FRAC_BITS);
  localparam logic signed [NRM_W-1:0] NRM_HI = NRM_W'(LIM_HI_I);
  localparam logic signed [NRM_W-1:0] NRM_LO = NRM_W'(LIM_LO_I);

  logic             v_s    [NST+1];
  logic             st_s   [NST+1];
  logic [SUM_W-1:0] s_s    [NST+1];
  logic [W-1:0]     e_s    [NST+1][LANES];
  logic [W-1:0]     p_s    [NST+1][LANES];
  logic [KW-1:0]    k_s    [NST+1][LANES];
  onrm_meta_t       meta_s [NST+1];

  logic signed [NRM_W-1:0] nrm [LANES];
  onrm_meta_t              meta_out;

  onrm_fold #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .stall_o     (in_stall_o),
    .enc_x_i     (enc_x_i),
    .enc_y_i     (enc_y_i),
    .material_i  (material_in_i),
    .frame_end_i (frame_end_in_i),
    .valid_o     (v_s[0]),
    .stall_i     (st_s[0]),
    .s_o         (s_s[0]),
    .e_o         (e_s[0]),
    .p_o         (p_s[0]),
    .meta_o      (meta_s[0])
  );

  for (genvar l = 0; l < LANES; l++) begin : g_k0
    assign k_s[0][l] = '0;
  end

  for (genvar g = 0; g < NST; g++) begin : g_root
    onrm_iter #(
      .FRAC_BITS (FRAC_BITS),
      .BIT       (FRAC_BITS - g)
    ) u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_s[g]),
      .stall_o (st_s[g]),
      .s_i     (s_s[g]),
      .e_i     (e_s[g]),
      .p_i     (p_s[g]),
      .k_i     (k_s[g]),
      .meta_i  (meta_s[g]),
      .valid_o (v_s[g+1]),
      .stall_i (st_s[g+1]),
      .s_o     (s_s[g+1]),
      .e_o     (e_s[g+1]),
      .p_o     (p_s[g+1]),
      .k_o     (k_s[g+1]),
      .meta_o  (meta_s[g+1])
    );
  end

  onrm_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_s[NST]),
    .stall_o (st_s[NST]),
    .s_i     (s_s[NST]),
    .e_i     (e_s[NST]),
    .p_i     (p_s[NST]),
    .k_i     (k_s[NST]),
    .meta_i  (meta_s[NST]),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .nrm_o   (nrm),
    .meta_o  (meta_out)
  );

  assign normal_x_o      = nrm[0];
  assign normal_y_o      = nrm[1];
  assign normal_z_o      = nrm[2];
  assign material_out_o  = meta_out.material;
  assign frame_end_out_o = meta_out.frame_end;

  // Requests are only held off when every stage is full and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the pipeline has room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (normal_x_o <= NRM_HI) && (normal_x_o >= NRM_LO) &&
                    (normal_y_o <= NRM_HI) && (normal_y_o >= NRM_LO) &&
                    (normal_z_o <= NRM_HI) && (normal_z_o >= NRM_LO))
    else $error("normal component outside unit range");

endmodule

>>> rtl/onrm_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octahedral normal decoder front end
// Unfolds the octahedral bytes into integer component magnitudes, squares
// them and sets up the per-component remainders for the root stages.
// ----------------------------------------------------------------------------
module onrm_fold #(
  parameter int unsigned FRAC_BITS = onrm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic [onrm_pkg::ENC_W-1:0]        enc_x_i,
  input  logic [onrm_pkg::ENC_W-1:0]        enc_y_i,
  input  logic [onrm_pkg::MAT_W-1:0]        material_i,
  input  logic                              frame_end_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic [onrm_pkg::SUM_W-1:0]        s_o,
  output logic [2*FRAC_BITS+23:0]           e_o [onrm_pkg::LANES],
  output logic [2*FRAC_BITS+23:0]           p_o [onrm_pkg::LANES],
  output onrm_pkg::onrm_meta_t              meta_o
);
  import onrm_pkg::*;

  localparam int unsigned W = 2 * FRAC_BITS + 24;

  // Stage 1: unfold
  logic [MAG_W-1:0] ax, ay;
  logic [MAG_W:0]   axy;
  logic             fold;
  logic [MAG_W:0]   mz_w;
  logic [MAG_W-1:0] mag_d [LANES];

  logic             v1_q, v2_q, v3_q;
  logic             st1, st2, st3;
  logic [MAG_W-1:0] mag1_q [LANES];
  onrm_meta_t       meta1_q, meta2_q, meta3_q;
  logic [SQ_W-1:0]  sq2_q [LANES];
  logic [SUM_W-1:0] s_d, s3_q;
  logic [W-1:0]     s_w;
  logic [W-1:0]     e_d [LANES];
  logic [W-1:0]     e3_q [LANES];
  logic [W-1:0]     p3_q;

  assign st3     = v3_q && stall_i;
  assign st2     = v2_q && st3;
  assign st1     = v1_q && st2;
  assign stall_o = st1;

  // 2v - 255 is odd; its magnitude is the low seven bits, inverted below mid-scale.
  assign ax   = {enc_x_i[7] ? enc_x_i[6:0] : ~enc_x_i[6:0], 1'b1};
  assign ay   = {enc_y_i[7] ? enc_y_i[6:0] : ~enc_y_i[6:0], 1'b1};
  assign axy  = {1'b0, ax} + {1'b0, ay};
  assign fold = axy > ENC_FULL;
  assign mz_w = fold ? (axy - ENC_FULL) : (ENC_FULL - axy);

  always_comb begin
    mag_d[0] = fold ? 8'(ENC_FULL - {1'b0, ay}) : ax;
    mag_d[1] = fold ? 8'(ENC_FULL - {1'b0, ax}) : ay;
    mag_d[2] = mz_w[MAG_W-1:0];
  end

  // Stage 3: sum of squares and initial remainders
  assign s_d = {2'b00, sq2_q[0]} + {2'b00, sq2_q[1]} + {2'b00, sq2_q[2]};
  assign s_w = {{(W-SUM_W){1'b0}}, s_d};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      e_d[l] = ({{(W-SQ_W){1'b0}}, sq2_q[l]} << (2 * FRAC_BITS + 2)) - s_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (!st1) v1_q <= valid_i;
      if (!st2) v2_q <= v1_q;
      if (!st3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !st1) begin
      mag1_q            <= mag_d;
      meta1_q.material  <= material_i;
      meta1_q.frame_end <= frame_end_i;
      meta1_q.neg       <= {fold, ~enc_y_i[7], ~enc_x_i[7]};
    end
    if (v1_q && !st2) begin
      for (int l = 0; l < LANES; l++) begin
        sq2_q[l] <= {{(SQ_W-MAG_W){1'b0}}, mag1_q[l]} * {{(SQ_W-MAG_W){1'b0}}, mag1_q[l]};
      end
      meta2_q <= meta1_q;
    end
    if (v2_q && !st3) begin
      s3_q    <= s_d;
      e3_q    <= e_d;
      p3_q    <= W'(0) - s_w;
      meta3_q <= meta2_q;
    end
  end

  assign valid_o = v3_q;
  assign s_o     = s3_q;
  assign e_o     = e3_q;
  assign meta_o  = meta3_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      p_o[l] = p3_q;
    end
  end

  // The unfolded magnitudes always lie on the octahedron |x| + |y| + |z| = 255.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> ({2'b00, mag1_q[0]} + {2'b00, mag1_q[1]} + {2'b00, mag1_q[2]}) == 10'd255)
    else $error("unfolded magnitudes leave the octahedron");

endmodule

>>> rtl/onrm_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octahedral normal decoder root stage
// Settles one bit of the rounded scaled magnitude for all three components
// by a shift, add and compare-subtract on the running remainder.
// ----------------------------------------------------------------------------
module onrm_iter #(
  parameter int unsigned FRAC_BITS = onrm_pkg::FRAC_BITS_DEF,
  parameter int unsigned BIT       = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [onrm_pkg::SUM_W-1:0]  s_i,
  input  logic [2*FRAC_BITS+23:0]     e_i [onrm_pkg::LANES],
  input  logic [2*FRAC_BITS+23:0]     p_i [onrm_pkg::LANES],
  input  logic [FRAC_BITS:0]          k_i [onrm_pkg::LANES],
  input  onrm_pkg::onrm_meta_t        meta_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [onrm_pkg::SUM_W-1:0]  s_o,
  output logic [2*FRAC_BITS+23:0]     e_o [onrm_pkg::LANES],
  output logic [2*FRAC_BITS+23:0]     p_o [onrm_pkg::LANES],
  output logic [FRAC_BITS:0]          k_o [onrm_pkg::LANES],
  output onrm_pkg::onrm_meta_t        meta_o
);
  import onrm_pkg::*;

  localparam int unsigned W  = 2 * FRAC_BITS + 24;
  localparam int unsigned KW = FRAC_BITS + 1;

  logic             v_q;
  logic             st;
  logic [W-1:0]     s_w;
  logic [W-1:0]     t_w    [LANES];
  logic [W-1:0]     diff_w [LANES];
  logic             take   [LANES];
  logic [W-1:0]     e_d    [LANES];
  logic [W-1:0]     p_d    [LANES];
  logic [KW-1:0]    k_d    [LANES];
  logic [SUM_W-1:0] s_q;
  logic [W-1:0]     e_q    [LANES];
  logic [W-1:0]     p_q    [LANES];
  logic [KW-1:0]    k_q    [LANES];
  onrm_meta_t       meta_q;

  assign st      = v_q && stall_i;
  assign stall_o = st;
  assign s_w     = {{(W-SUM_W){1'b0}}, s_i};

  // With u = 2k - 1 and P = u * s, raising k by 2^BIT grows u^2 * s by
  // P * 2^(BIT+2) + s * 2^(2*BIT+2). The bit is kept when that still fits.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      t_w[l]    = (p_i[l] << (BIT + 2)) + (s_w << (2 * BIT + 2));
      diff_w[l] = e_i[l] - t_w[l];
      take[l]   = ~diff_w[l][W-1];
      e_d[l]    = take[l] ? diff_w[l] : e_i[l];
      p_d[l]    = take[l] ? (p_i[l] + (s_w << (BIT + 1))) : p_i[l];
      k_d[l]    = k_i[l] | ({{(KW-1){1'b0}}, take[l]} << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!st) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !st) begin
      s_q    <= s_i;
      e_q    <= e_d;
      p_q    <= p_d;
      k_q    <= k_d;
      meta_q <= meta_i;
    end
  end

  assign valid_o = v_q;
  assign s_o     = s_q;
  assign e_o     = e_q;
  assign p_o     = p_q;
  assign k_o     = k_q;
  assign meta_o  = meta_q;

endmodule

>>> rtl/onrm_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octahedral normal decoder output stage
// Applies the component signs, saturates to the 16-bit field and holds the
// finished result in the output register.
// ----------------------------------------------------------------------------
module onrm_out #(
  parameter int unsigned FRAC_BITS = onrm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic [onrm_pkg::SUM_W-1:0]         s_i,
  input  logic [2*FRAC_BITS+23:0]            e_i [onrm_pkg::LANES],
  input  logic [2*FRAC_BITS+23:0]            p_i [onrm_pkg::LANES],
  input  logic [FRAC_BITS:0]                 k_i [onrm_pkg::LANES],
  input  onrm_pkg::onrm_meta_t               meta_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic signed [onrm_pkg::NRM_W-1:0]  nrm_o [onrm_pkg::LANES],
  output onrm_pkg::onrm_meta_t               meta_o
);
  import onrm_pkg::*;

  localparam int unsigned W  = 2 * FRAC_BITS + 24;
  localparam int unsigned MW = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;

  logic             v_q;
  logic             st;
  logic [MW-1:0]    kx    [LANES];
  logic [NRM_W-1:0] nrm_d [LANES];
  logic [NRM_W-1:0] nrm_q [LANES];
  onrm_meta_t       meta_q;

  assign st      = v_q && stall_i;
  assign stall_o = st;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      kx[l] = {{(MW-FRAC_BITS-1){1'b0}}, k_i[l]};
      if (meta_i.neg[l]) begin
        if (kx[l] > {{(MW-NRM_W){1'b0}}, NRM_NEG_MAX}) begin
          nrm_d[l] = NRM_NEG_MAX;
        end else begin
          nrm_d[l] = {NRM_W{1'b0}} - kx[l][NRM_W-1:0];
        end
      end else begin
        if (kx[l] > {{(MW-NRM_W){1'b0}}, NRM_POS_MAX}) begin
          nrm_d[l] = NRM_POS_MAX;
        end else begin
          nrm_d[l] = kx[l][NRM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!st) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !st) begin
      nrm_q  <= nrm_d;
      meta_q <= meta_i;
    end
  end

  assign valid_o = v_q;
  assign meta_o  = meta_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      nrm_o[l] = $signed(nrm_q[l]);
    end
  end

  // Once any bit has been kept, the remainder can no longer be negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ((k_i[0] == '0) || !e_i[0][W-1]) && ((k_i[1] == '0) || !e_i[1][W-1]) &&
                ((k_i[2] == '0) || !e_i[2][W-1]))
    else $error("root remainder negative after a kept bit");

  // P is an odd multiple of s, so it shares the parity of s.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (p_i[0][0] == s_i[0]) && (p_i[1][0] == s_i[0]) && (p_i[2][0] == s_i[0]))
    else $error("root product lost its odd multiplier");

endmodule

>>> dv/octahedral_normal_decoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octahedral normal decoder testbench
// Sends pixel requests through the decoder under random sender bursts and
// receiver stalls. Each accepted request is decoded by an exact integer
// predictor, and every result is compared field by field, in order.
// ----------------------------------------------------------------------------
module octahedral_normal_decoder_top_test;
  import onrm_pkg::*;

  localparam int unsigned FRAC        = FRAC_BITS_DEF;
  localparam int unsigned LATENCY     = FRAC + 5;
  localparam int unsigned RANDOM_PIX  = 1030;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [ENC_W-1:0] enc_x;
    logic [ENC_W-1:0] enc_y;
    logic [MAT_W-1:0] material;
    logic             frame_end;
    logic             hold;
  } pixel_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic [MAT_W-1:0]        material;
    logic                    frame_end;
    logic                    folded;
  } normal_res_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [ENC_W-1:0]        enc_x_i = '0;
  logic [ENC_W-1:0]        enc_y_i = '0;
  logic [MAT_W-1:0]        material_in_i = '0;
  logic                    frame_end_in_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [NRM_W-1:0] normal_x_o;
  logic signed [NRM_W-1:0] normal_y_o;
  logic signed [NRM_W-1:0] normal_z_o;
  logic [MAT_W-1:0]        material_out_o;
  logic                    frame_end_out_o;

  pixel_t      pixels_to_send[$];
  normal_res_t normals_due[$];

  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_issued = 0;
  int unsigned n_checked = 0;
  int unsigned n_folded = 0;
  int unsigned n_frame_ends = 0;
  int unsigned cycle_cnt = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_mode = 0;

  octahedral_normal_decoder_top #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .enc_x_i(enc_x_i),
    .enc_y_i(enc_y_i),
    .material_in_i(material_in_i),
    .frame_end_in_i(frame_end_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .normal_x_o(normal_x_o),
    .normal_y_o(normal_y_o),
    .normal_z_o(normal_z_o),
    .material_out_o(material_out_o),
    .frame_end_out_o(frame_end_out_o)
  );

  always #10 clk_i = ~clk_i;

  // Rounded magnitude |comp| * 2^FRAC / sqrt(sumsq), found as the largest k
  // with (2k - 1)^2 * sumsq <= 4 * comp^2 * 4^FRAC, then signed and clamped.
  function automatic logic signed [NRM_W-1:0] scale_axis(longint signed comp,
                                                         longint unsigned sumsq);
    longint unsigned mag, lim, lo, hi, mid, odd;
    longint signed   k;
    mag = (comp < 0) ? -comp : comp;
    lim = (mag * mag) << (2 * FRAC + 2);
    if (sumsq == 0) return '0;
    lo = 0;
    hi = longint'(1) << FRAC;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      odd = 2 * mid - 1;
      if (odd * odd * sumsq <= lim) lo = mid;
      else hi = mid - 1;
    end
    k = (comp < 0) ? -longint'(lo) : longint'(lo);
    if (k > 32767) k = 32767;
    if (k < -32768) k = -32768;
    return k[NRM_W-1:0];
  endfunction

  // Everything is kept in units of 1/255, so the components stay integers.
  function automatic normal_res_t decode_pixel(logic [ENC_W-1:0] bx, logic [ENC_W-1:0] by,
                                               logic [MAT_W-1:0] mat, logic fe);
    longint signed   ex, ey, ax, ay, vx, vy, vz;
    longint unsigned sumsq;
    normal_res_t     res;
    ex = 2 * longint'(bx) - 255;
    ey = 2 * longint'(by) - 255;
    ax = (ex < 0) ? -ex : ex;
    ay = (ey < 0) ? -ey : ey;
    vx = ex;
    vy = ey;
    vz = 255 - ax - ay;
    if (vz < 0) begin
      vx = (ex >= 0) ? (255 - ay) : -(255 - ay);
      vy = (ey >= 0) ? (255 - ax) : -(255 - ax);
    end
    sumsq = vx * vx + vy * vy + vz * vz;
    res.nx = scale_axis(vx, sumsq);
    res.ny = scale_axis(vy, sumsq);
    res.nz = scale_axis(vz, sumsq);
    res.material = mat;
    res.frame_end = fe;
    res.folded = (vz < 0);
    return res;
  endfunction

  function automatic logic [ENC_W-1:0] rim_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd126;
      3: return 8'd127;
      4: return 8'd128;
      5: return 8'd129;
      6: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t      px;
    int unsigned pick, ax;
    int signed   t;
    px = '0;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      px.enc_x = ENC_W'($urandom_range(0, 255));
      px.enc_y = ENC_W'($urandom_range(0, 255));
    end else if (pick < 7) begin
      px.enc_x = rim_byte();
      px.enc_y = ($urandom_range(0, 1) != 0) ? rim_byte() : ENC_W'($urandom_range(0, 255));
    end else begin
      // Land within a few steps of the fold line, where z changes sign.
      px.enc_x = ENC_W'($urandom_range(0, 255));
      ax = (px.enc_x >= 128) ? 2 * px.enc_x - 255 : 255 - 2 * px.enc_x;
      t = 255 - int'(ax) + 2 * int'($urandom_range(0, 3)) - 3;
      if (t < 1) t = 1;
      if (t > 255) t = 255;
      px.enc_y = ($urandom_range(0, 1) != 0) ? ENC_W'((255 + t) / 2) : ENC_W'((255 - t) / 2);
    end
    case ($urandom_range(0, 15))
      0: px.material = 8'd0;
      1: px.material = 8'd255;
      default: px.material = MAT_W'($urandom_range(0, 255));
    endcase
    px.frame_end = ($urandom_range(0, 19) == 0);
    return px;
  endfunction

  task automatic queue_pixel(int unsigned bx, int unsigned by, int unsigned mat,
                             bit fe, bit hold);
    pixel_t px;
    px.enc_x = ENC_W'(bx);
    px.enc_y = ENC_W'(by);
    px.material = MAT_W'(mat);
    px.frame_end = fe;
    px.hold = hold;
    pixels_to_send.insert(pixels_to_send.size(), px);
  endtask

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("MISMATCH at %0d ns: %s", $time, msg);
  endtask

  task automatic check_result(normal_res_t due);
    if (normal_x_o !== due.nx)
      report_mismatch($sformatf("normal_x got %0d want %0d", normal_x_o, due.nx));
    if (normal_y_o !== due.ny)
      report_mismatch($sformatf("normal_y got %0d want %0d", normal_y_o, due.ny));
    if (normal_z_o !== due.nz)
      report_mismatch($sformatf("normal_z got %0d want %0d", normal_z_o, due.nz));
    if (material_out_o !== due.material)
      report_mismatch($sformatf("material got %0d want %0d", material_out_o, due.material));
    if (frame_end_out_o !== due.frame_end)
      report_mismatch($sformatf("frame_end got %0b want %0b", frame_end_out_o, due.frame_end));
  endtask

  // Results are taken before new requests are recorded: the pipeline latency
  // means a result never belongs to a request accepted on the same edge.
  always @(posedge clk_i) begin : scoreboard
    normal_res_t due;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (normals_due.size() == 0) begin
          report_mismatch($sformatf("result with no request pending, x=%0d y=%0d z=%0d",
                                    normal_x_o, normal_y_o, normal_z_o));
        end else begin
          due = normals_due.pop_front();
          check_result(due);
          n_checked++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        due = decode_pixel(enc_x_i, enc_y_i, material_in_i, frame_end_in_i);
        normals_due.insert(normals_due.size(), due);
        n_sent++;
        if (due.folded) n_folded++;
        if (due.frame_end) n_frame_ends++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt,
               normals_due.size());
      $display("octahedral_normal_decoder_top_test: done, errors");
      $finish;
    end
  end

  // Sender: bursts of random length, separated by random gaps, sometimes none.
  always @(negedge clk_i) begin : send_pixels
    pixel_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && (n_issued != n_sent)) begin
      // Request still stalled: hold the payload as it is.
    end else begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pixels_to_send.size() != 0 &&
                   !(pixels_to_send[0].hold && normals_due.size() != 0)) begin
        nxt = pixels_to_send.pop_front();
        enc_x_i <= nxt.enc_x;
        enc_y_i <= nxt.enc_y;
        material_in_i <= nxt.material;
        frame_end_in_i <= nxt.frame_end;
        in_valid_i <= 1'b1;
        n_issued++;
        if (burst_left > 0) burst_left = burst_left - 1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          case ($urandom_range(0, 5))
            0, 1: gap_left = 0;
            2: gap_left = $urandom_range(10, 30);
            default: gap_left = $urandom_range(1, 5);
          endcase
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: a new stall habit each time stall_phase wraps, from none at all to long holds.
  always @(negedge clk_i) begin : receiver_stall
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_phase == 0) stall_mode = $urandom_range(0, 4);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        2: out_stall_i <= ($urandom_range(0, 9) < 8);
        3: out_stall_i <= stall_phase[2];
        default: out_stall_i <= (stall_phase < 30);
      endcase
      stall_phase = (stall_phase + 1) % 64;
    end
  end

  initial begin : run
    pixel_t px;
    // Corners, centre bytes, both sides of the fold line and pass-through extremes.
    queue_pixel(0, 0, 0, 1'b0, 1'b0);
    queue_pixel(255, 255, 255, 1'b1, 1'b0);
    queue_pixel(0, 255, 8'h55, 1'b0, 1'b0);
    queue_pixel(255, 0, 8'hAA, 1'b1, 1'b0);
    queue_pixel(127, 127, 1, 1'b0, 1'b0);
    queue_pixel(128, 128, 254, 1'b0, 1'b0);
    queue_pixel(127, 128, 128, 1'b0, 1'b0);
    queue_pixel(128, 127, 127, 1'b1, 1'b0);
    queue_pixel(64, 64, 0, 1'b0, 1'b0);
    queue_pixel(191, 191, 255, 1'b0, 1'b0);
    queue_pixel(63, 63, 3, 1'b0, 1'b0);
    queue_pixel(192, 192, 7, 1'b0, 1'b0);
    queue_pixel(64, 191, 15, 1'b0, 1'b0);
    queue_pixel(192, 63, 31, 1'b0, 1'b0);
    queue_pixel(0, 127, 63, 1'b0, 1'b0);
    queue_pixel(255, 128, 64, 1'b0, 1'b0);
    queue_pixel(127, 0, 200, 1'b0, 1'b0);
    queue_pixel(128, 255, 240, 1'b0, 1'b0);
    queue_pixel(1, 254, 16, 1'b0, 1'b0);
    queue_pixel(254, 1, 32, 1'b0, 1'b0);
    queue_pixel(1, 1, 99, 1'b0, 1'b0);
    queue_pixel(254, 254, 255, 1'b1, 1'b0);
    for (int i = 0; i < RANDOM_PIX; i++) begin
      px = random_pixel();
      // Now and then let the decoder drain completely before going on.
      px.hold = (i == 0) || ($urandom_range(0, 299) == 0);
      pixels_to_send.insert(pixels_to_send.size(), px);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pixels_to_send.size() != 0 || in_valid_i) @(posedge clk_i);
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("Decoded %0d pixel requests (%0d folded, %0d frame ends), %0d results checked.",
             n_sent, n_folded, n_frame_ends, n_checked);
    $display("Mismatches found: %0d, run length %0d cycles.", n_errors, cycle_cnt);
    if (n_errors == 0) begin
      $display("octahedral_normal_decoder_top_test: done, clean");
    end else begin
      $display("octahedral_normal_decoder_top_test: done, errors");
    end
    $finish;
  end

endmodule
